// File: hw/rtl/qdt_pkg.sv
// shared types and constants for the quoted delimiter tokenizer
`timescale 1ns / 1ps

package qdt_pkg;

	localparam int BYTE_W   = 8;
	localparam int MASK_W   = 64;
	localparam int DELIM_W  = 256;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELIM_A = 3'd0,
		REG_DELIM_B = 3'd1,
		REG_DELIM_C = 3'd2,
		REG_DELIM_D = 3'd3,
		REG_MODE    = 3'd4
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
	localparam logic [BYTE_W-1:0] CH_N      = 8'h6e;
	localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
	localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

	typedef struct packed {
		logic inside_token;
		logic inside_quote;
		logic escape_pending;
	} tok_state_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] out_byte;
		logic              has_byte;
		logic              token_done;
	} tok_result_t;

endpackage

// File: hw/rtl/qdt_step.sv
// per-byte tokenizer decision: next state and result for one text byte
`timescale 1ns / 1ps

module qdt_step (
	input  qdt_pkg::tok_state_t             cur_state,
	input  logic [qdt_pkg::BYTE_W-1:0]      text_byte,
	input  logic                            text_final,
	input  logic                            full_mode,
	input  logic [qdt_pkg::DELIM_W-1:0]     delim_set,
	output qdt_pkg::tok_state_t             next_state,
	output qdt_pkg::tok_result_t            result
);
	import qdt_pkg::*;

	logic              is_delim;
	logic              emit;
	logic              done;
	logic [BYTE_W-1:0] ob;
	tok_state_t        st;

	assign is_delim = delim_set[text_byte];

	always_comb begin
		st   = cur_state;
		emit = 1'b0;
		done = 1'b0;
		ob   = CH_NUL;

		// simple mode forgets any quote or escape context
		if (!full_mode) begin
			st.inside_quote   = 1'b0;
			st.escape_pending = 1'b0;
		end

		if (st.escape_pending) begin
			st.escape_pending = 1'b0;
			case (text_byte)
				CH_N: begin
					ob   = CH_LF;
					emit = 1'b1;
				end
				CH_T: begin
					ob   = CH_TAB;
					emit = 1'b1;
				end
				CH_R: begin
					ob   = CH_CR;
					emit = 1'b1;
				end
				CH_NUL: begin
					emit = 1'b0;
				end
				default: begin
					ob   = text_byte;
					emit = 1'b1;
				end
			endcase
		end else if (is_delim && !(st.inside_token && st.inside_quote)) begin
			if (st.inside_token) begin
				done            = 1'b1;
				st.inside_token = 1'b0;
				st.inside_quote = 1'b0;
			end
		end else begin
			if (!st.inside_token) begin
				st.inside_token = 1'b1;
				st.inside_quote = 1'b0;
			end
			if (full_mode && text_byte == CH_QUOTE) begin
				st.inside_quote = !st.inside_quote;
			end else if (full_mode && text_byte == CH_BSLASH) begin
				st.escape_pending = 1'b1;
			end else begin
				ob   = text_byte;
				emit = 1'b1;
			end
		end

		// end of text closes any open token and clears all context
		if (text_final) begin
			if (st.inside_token) begin
				done = 1'b1;
			end
			st = '0;
		end
	end

	assign next_state        = st;
	assign result.valid      = emit || done;
	assign result.out_byte   = ob;
	assign result.has_byte   = emit;
	assign result.token_done = done;

endmodule

// File: hw/rtl/quoted_delimiter_tokenizer.sv
// top level of the quoted delimiter tokenizer: handshakes, registers, config
`timescale 1ns / 1ps
// path: a request accepted on the input is held in the input stage register, and its
//   step result is then registered in the output register that drives out_valid
// throughput: one text byte per cycle unless out_stall holds a full output register,
//   set by the single-pass step logic between the input stage and output registers
// reset: state bits and valid flags clear, delimiter masks clear, full mode on
// a byte that closes nothing and emits nothing yields no output request

module quoted_delimiter_tokenizer (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [qdt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qdt_pkg::MASK_W-1:0]       cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [qdt_pkg::BYTE_W-1:0]       in_byte,
	input  logic                             final_byte,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [qdt_pkg::BYTE_W-1:0]       out_byte,
	output logic                             has_byte,
	output logic                             token_done
);
	import qdt_pkg::*;

	// configuration registers
	logic [MASK_W-1:0] delim_a_q;
	logic [MASK_W-1:0] delim_b_q;
	logic [MASK_W-1:0] delim_c_q;
	logic [MASK_W-1:0] delim_d_q;
	logic              mode_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              final_s1;

	// tokenizer context
	tok_state_t  state_q;
	tok_state_t  state_next;
	tok_result_t step_res;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              has_byte_q;
	logic              token_done_q;

	logic in_take;
	logic advance_s1;

	// stage 1 retires when the output register is empty or draining this cycle
	assign advance_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign in_take    = in_valid && !in_stall;

	// configuration writes; indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_a_q <= '0;
			delim_b_q <= '0;
			delim_c_q <= '0;
			delim_d_q <= '0;
			mode_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELIM_A: delim_a_q <= cfg_data;
				REG_DELIM_B: delim_b_q <= cfg_data;
				REG_DELIM_C: delim_c_q <= cfg_data;
				REG_DELIM_D: delim_d_q <= cfg_data;
				REG_MODE:    mode_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= in_byte;
			final_s1 <= final_byte;
		end
	end

	// per-byte decision logic
	qdt_step u_step (
		.cur_state  (state_q),
		.text_byte  (byte_s1),
		.text_final (final_s1),
		.full_mode  (mode_q),
		.delim_set  ({delim_d_q, delim_c_q, delim_b_q, delim_a_q}),
		.next_state (state_next),
		.result     (step_res)
	);

	// context only moves when a byte retires from stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_next;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && step_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance_s1 && step_res.valid) begin
			out_byte_q   <= step_res.out_byte;
			has_byte_q   <= step_res.has_byte;
			token_done_q <= step_res.token_done;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign has_byte   = has_byte_q;
	assign token_done = token_done_q;

endmodule

// File: tb/sv/tb_quoted_delimiter_tokenizer.sv
// self-checking testbench for the quoted delimiter tokenizer
`timescale 1ns / 1ps

module tb_quoted_delimiter_tokenizer;
	import qdt_pkg::*;

	localparam int RESET_CYCLES   = 7;
	localparam int RANDOM_BYTES   = 700;
	localparam int SETTLE_CYCLES  = 4;     // block holds a byte in its input stage and output register, leave margin
	localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
	localparam int HOLD_AFTER     = 120;   // results seen before the long output hold
	localparam int HOLD_CYCLES    = 150;
	localparam int MAX_REPORTS    = 20;

	// one text byte as offered on the input channel
	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              last;
	} text_byte_t;

	// one predicted output request
	typedef struct {
		logic [BYTE_W-1:0] out_byte;
		logic              has_byte;
		logic              token_done;
	} token_event_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	// block inputs, all known from time zero
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [MASK_W-1:0]     cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic [BYTE_W-1:0]     in_byte    = '0;
	logic                  final_byte = 1'b0;
	logic                  out_stall  = 1'b0;

	// block outputs
	logic                  in_stall;
	logic                  out_valid;
	logic [BYTE_W-1:0]     out_byte;
	logic                  has_byte;
	logic                  token_done;

	quoted_delimiter_tokenizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.token_done (token_done)
	);

	// bytes waiting to be offered, front one is on the bus when in_valid is high
	text_byte_t   text_bytes[$];
	// token output the block still owes, oldest first
	token_event_t expected_token_events[$];

	// shadow of the block: delimiter set, mode and scanner flags
	logic [DELIM_W-1:0] delim_set = '0;
	logic               full_mode = 1'b1;
	tok_state_t         scan      = '0;

	// bookkeeping
	int queued_bytes    = 0;
	int accepted_bytes  = 0;
	int texts_ended     = 0;
	int results_checked = 0;
	int settings_loaded = 0;
	int mismatches      = 0;
	int quiet_cycles    = 0;

	// sender and receiver pacing
	int send_gap   = 0;
	int send_calm  = 0;
	int recv_gap   = 0;
	int recv_calm  = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;

	// scanner step for one accepted byte, queues the output it should cause
	task automatic tokenize_byte(input logic [BYTE_W-1:0] b, input logic fin);
		logic              emit;
		logic              done;
		logic [BYTE_W-1:0] ob;
		emit = 1'b0;
		done = 1'b0;
		ob   = '0;
		// plain split forgets any quote or escape left from full mode
		if (!full_mode) begin
			scan.inside_quote   = 1'b0;
			scan.escape_pending = 1'b0;
		end
		if (scan.escape_pending) begin
			// escaped byte skips the delimiter test entirely
			scan.escape_pending = 1'b0;
			case (b)
				CH_N:    ob = CH_LF;
				CH_T:    ob = CH_TAB;
				CH_R:    ob = CH_CR;
				default: ob = b;
			endcase
			emit = (b != CH_NUL);
		end else if (delim_set[b] && !(scan.inside_token && scan.inside_quote)) begin
			// delimiter closes an open token, runs of them yield nothing
			if (scan.inside_token) begin
				done              = 1'b1;
				scan.inside_token = 1'b0;
				scan.inside_quote = 1'b0;
			end
		end else begin
			if (!scan.inside_token) begin
				scan.inside_token = 1'b1;
				scan.inside_quote = 1'b0;
			end
			if (full_mode && b == CH_QUOTE) begin
				scan.inside_quote = !scan.inside_quote;
			end else if (full_mode && b == CH_BSLASH) begin
				scan.escape_pending = 1'b1;
			end else begin
				ob   = b;
				emit = 1'b1;
			end
		end
		// end of text closes the token and clears every flag
		if (fin) begin
			if (scan.inside_token)
				done = 1'b1;
			scan = '0;
			texts_ended++;
		end
		if (emit || done)
			expected_token_events.push_back('{ob, emit, done});
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin);
		text_bytes.push_back('{b, fin});
		queued_bytes++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b0);
	endtask

	// write all five registers through the config port, block must be idle
	task automatic load_settings(input logic [MASK_W-1:0] a, input logic [MASK_W-1:0] b,
			input logic [MASK_W-1:0] c, input logic [MASK_W-1:0] d, input logic mode);
		logic [MASK_W-1:0] vals [5];
		cfg_reg_t          regs [5];
		vals = '{a, b, c, d, {{(MASK_W-1){1'b0}}, mode}};
		regs = '{REG_DELIM_A, REG_DELIM_B, REG_DELIM_C, REG_DELIM_D, REG_MODE};
		for (int i = 0; i < 5; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
		end
		@(posedge clk);
		cfg_we    <= 1'b0;
		delim_set = {d, c, b, a};
		full_mode = mode;
		settings_loaded++;
	endtask

	// wait until everything offered is accepted and answered, then let the pipe drain
	task automatic settle(input int extra);
		while (text_bytes.size() != 0 || expected_token_events.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	function automatic logic [MASK_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// a byte marked as delimiter, or any byte when the set is empty
	function automatic logic [BYTE_W-1:0] pick_delim();
		logic [BYTE_W-1:0] b;
		b = '0;
		for (int i = 0; i < 32; i++) begin
			b = BYTE_W'($urandom_range(0, 255));
			if (delim_set[b])
				return b;
		end
		return b;
	endfunction

	// an ordinary token byte: not a delimiter, not a quote or backslash in full mode
	function automatic logic [BYTE_W-1:0] pick_plain();
		logic [BYTE_W-1:0] b;
		b = '0;
		for (int i = 0; i < 32; i++) begin
			b = BYTE_W'($urandom_range(0, 255));
			if (!delim_set[b] && !(full_mode && (b == CH_QUOTE || b == CH_BSLASH)))
				return b;
		end
		return b;
	endfunction

	task automatic report_mismatch(input string field, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	// driver: offers the front byte, keeps it steady while stalled
	always @(posedge clk) begin : driver
		logic took;
		took = in_valid && !in_stall;
		if (took) begin
			tokenize_byte(text_bytes[0].value, text_bytes[0].last);
			text_bytes.pop_front();
			accepted_bytes++;
			// stretches with no gaps at all, otherwise random pacing
			if (send_calm > 0) begin
				send_calm--;
				send_gap = 0;
			end else begin
				send_gap = pick_gap();
				if ($urandom_range(0, 39) == 0)
					send_calm = 50;
			end
		end
		if (!in_valid || took) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (text_bytes.size() != 0) begin
				in_valid   <= 1'b1;
				in_byte    <= text_bytes[0].value;
				final_byte <= text_bytes[0].last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each accepted output request and paces out_stall
	always @(posedge clk) begin : monitor
		token_event_t want;
		if (out_valid && !out_stall) begin
			results_checked++;
			if (expected_token_events.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %0h/%0b/%0b",
						$time, out_byte, has_byte, token_done);
			end else begin
				want = expected_token_events.pop_front();
				if (out_byte !== want.out_byte)
					report_mismatch("out_byte", want.out_byte, out_byte);
				if (has_byte !== want.has_byte)
					report_mismatch("has_byte", {{(BYTE_W-1){1'b0}}, want.has_byte},
						{{(BYTE_W-1){1'b0}}, has_byte});
				if (token_done !== want.token_done)
					report_mismatch("token_done", {{(BYTE_W-1){1'b0}}, want.token_done},
						{{(BYTE_W-1){1'b0}}, token_done});
			end
		end
		// one long hold so the block backs up into its input
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && results_checked >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (recv_calm > 0) begin
				recv_calm--;
			end else begin
				recv_gap = pick_gap();
				if ($urandom_range(0, 39) == 0)
					recv_calm = 50;
			end
		end
	end

	// watchdog: nothing moving on either channel for too long ends the run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d bytes still queued, %0d results owed",
					$time, text_bytes.size(), expected_token_events.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// stimulus: directed texts first, then random phases under changing settings
	initial begin : stimulus
		int                phase;
		int                phase_end;
		int                directed_bytes;
		int                ntok;
		int                npiece;
		logic [MASK_W-1:0] typical;
		phase = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: NUL, space, comma, bar, 0x80 and 0xff are delimiters, full mode
		load_settings((64'd1 << 0) | (64'd1 << 32) | (64'd1 << 44), 64'd1 << 60,
			64'd1, 64'd1 << 63, 1'b1);
		push_text("\"\" ");            // quote opens a token that closes empty
		push_text("\\n\\t\\r");        // the three control escapes
		push_byte(CH_BSLASH, 1'b0);    // escaped NUL: dropped, not a delimiter
		push_byte(CH_NUL, 1'b0);
		push_byte(8'h80, 1'b0);        // high delimiter closes
		push_text("\" ,\"");           // quoted delimiters are literal
		push_byte(8'hff, 1'b0);
		push_text("x");
		push_byte(CH_BSLASH, 1'b1);    // backslash as last byte closes without a byte
		push_byte(8'h01, 1'b1);        // last byte emits and closes in one result
		push_byte(8'h20, 1'b1);        // last byte a delimiter between tokens: silent
		push_text("q");
		push_byte(8'h2c, 1'b1);        // last byte a delimiter that closes a token
		push_text("\"a");              // left open, quoted, across the mode change
		settle(SETTLE_CYCLES);

		// same set, plain split: open quote is forgotten, quote and backslash pass
		load_settings((64'd1 << 0) | (64'd1 << 32) | (64'd1 << 44), 64'd1 << 60,
			64'd1, 64'd1 << 63, 1'b0);
		push_text(" \"\\");
		push_byte(8'h61, 1'b1);
		directed_bytes = queued_bytes;

		while (queued_bytes < directed_bytes + RANDOM_BYTES) begin
			settle(SETTLE_CYCLES);
			typical = (64'd1 << 9) | (64'd1 << 32) | (64'd1 << 44) | (64'd1 << 59);
			case (phase % 5)
				0: load_settings(typical, rand64() & rand64() & rand64(), '0, rand64() & rand64(),
					1'b1);
				1: load_settings('0, '0, '0, '0, 1'b0);
				2: load_settings('1, '1, '1, '1, 1'b1);  // everything splits
				3: load_settings('0, '0, '0, '0, 1'b1);  // only the last byte closes
				default: load_settings(rand64() & rand64(), rand64() & rand64(),
					rand64() & rand64(), rand64() & rand64(), 1'($urandom_range(0, 1)));
			endcase
			phase_end = queued_bytes + ((phase % 5 == 2) ? 30 : 90);
			while (queued_bytes < phase_end) begin
				if ($urandom_range(0, 4) == 0) begin
					// noise burst, may stop mid-text so a setting change lands inside one
					repeat ($urandom_range(1, 8))
						push_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				end else begin
					// well-formed text: tokens with quotes and escapes between delimiter runs
					ntok = $urandom_range(1, 4);
					for (int t = 0; t < ntok; t++) begin
						if ($urandom_range(0, 2) == 0)
							repeat ($urandom_range(1, 3)) push_byte(pick_delim(), 1'b0);
						npiece = $urandom_range(0, 5);
						for (int p = 0; p < npiece; p++) begin
							case ($urandom_range(0, 9))
								0, 1, 2, 3, 4: push_byte(pick_plain(), 1'b0);
								5, 6: begin
									push_byte(CH_QUOTE, 1'b0);
									repeat ($urandom_range(0, 4))
										push_byte(($urandom_range(0, 2) == 0) ? pick_delim()
											: pick_plain(), 1'b0);
									// sometimes the quote is never closed
									if ($urandom_range(0, 5) != 0)
										push_byte(CH_QUOTE, 1'b0);
								end
								7, 8: begin
									push_byte(CH_BSLASH, 1'b0);
									case ($urandom_range(0, 6))
										0: push_byte(CH_N, 1'b0);
										1: push_byte(CH_T, 1'b0);
										2: push_byte(CH_R, 1'b0);
										3: push_byte(CH_NUL, 1'b0);
										4: push_byte(pick_delim(), 1'b0);
										5: push_byte(CH_QUOTE, 1'b0);
										default: push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
									endcase
								end
								default: push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
							endcase
						end
						if (t < ntok - 1)
							repeat ($urandom_range(1, 3)) push_byte(pick_delim(), 1'b0);
					end
					// how the text ends: delimiter, dangling backslash or token byte
					case ($urandom_range(0, 3))
						0: push_byte(pick_delim(), 1'b1);
						1: push_byte(CH_BSLASH, 1'b1);
						default: push_byte(pick_plain(), 1'b1);
					endcase
				end
			end
			phase++;
		end

		settle(SETTLE_CYCLES * 3);
		$display("run covered %0d text bytes (%0d directed) in %0d texts over %0d settings",
			accepted_bytes, directed_bytes, texts_ended, settings_loaded);
		$display("checked %0d token results, long output hold %s",
			results_checked, hold_done ? "applied" : "not reached");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
